FILE: rtl/dgpf_pkg.sv
`timescale 1ns / 1ps

package dgpf_pkg;

    // Fixed widths and the reset value of the scale register.
    localparam int SCALE_W     = 12;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 12'd256;
    localparam int ACTION_W    = 2;

    // Defaults for the coordinate format.
    localparam int COORD_WIDTH_DEF = 16;
    localparam int COORD_FRAC_DEF  = 4;

    // What happened to the held point on one word.
    typedef enum logic [ACTION_W-1:0] {
        ACT_FIRST = 2'd0,
        ACT_HOLD  = 2'd1,
        ACT_SNAP  = 2'd2,
        ACT_GLIDE = 2'd3
    } t_action;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQRT,
        ST_DECIDE,
        ST_MUL_X,
        ST_DIV_X,
        ST_MUL_Y,
        ST_DIV_Y,
        ST_FIN
    } t_state;

endpackage

FILE: rtl/deadband_glide_point_filter.sv
`timescale 1ns / 1ps

// Deadband glide point filter. Each input word carries a raw 2D point; the block keeps a held
// point and returns it, with an action code, once per word. The first point after reset, or
// one with restart set, is taken as is; a later point within 2*scale pixels of the held point
// leaves it alone, one at 24*scale or more snaps to it, and one in between glides the held
// point toward it by 0.2*(d-2*scale)/d of the offset. A point that is taken, or that snaps on
// one axis offset alone, goes from acceptance through ST_PREP to ST_FIN. One that needs the
// distance and is then held or snapped also passes through ST_SQ_X, ST_SQ_Y, ST_SQRT and
// ST_DECIDE, and a glided one then through ST_MUL_X, ST_DIV_X, ST_MUL_Y and ST_DIV_Y; each
// result is valid from the same cycle in which the next word can be accepted. The work runs on
// one shared multiplier and compare-subtract unit: one root bit per cycle for the distance,
// then one quotient bit per cycle for each axis. The block takes no new word while one is at
// work; a finished result waits in the output register while the next word is accepted, and
// the next word stalls in its last cycle until that register has been taken.
module deadband_glide_point_filter import dgpf_pkg::*; #(
    parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
    parameter int COORD_FRAC_BITS = COORD_FRAC_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // Scale register write channel.
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [SCALE_W-1:0] i_cfg_data,
    // Raw points in.
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // tdata: raw_x, raw_y, zero fill
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // tuser: restart
    input  logic s_axis_tuser,
    // Shown points out.
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // tdata: shown_x, shown_y, zero fill
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // tuser: action
    output logic [ACTION_W-1:0] m_axis_tuser
);

    localparam int CW     = COORD_WIDTH;
    localparam int F      = COORD_FRAC_BITS;
    localparam int TD_W   = ((2*CW+7)/8)*8;
    localparam int DW     = CW + 1;              // coordinate difference
    localparam int AX_W   = 9 + F;               // axis offset below the snap distance
    localparam int TH_W   = 17 + F;              // thresholds and glide numerator
    localparam int PW     = AX_W + TH_W;         // products
    localparam int SQE    = 20 + 2*F;            // sum of squares, even width
    localparam int D_W    = 10 + F;              // distance
    localparam int DC_W   = D_W + 8;             // distance times 256
    localparam int DEN_W  = 21 + F;              // 1280 times distance
    localparam int QW     = AX_W;                // glide step
    localparam int SW     = (DEN_W + QW - 1 > PW) ? DEN_W + QW - 1 : PW; // remainder, divider
    localparam int MC_W   = (DW + 8 > TH_W) ? DW + 8 : TH_W;
    localparam int G_W    = ((AX_W > CW) ? AX_W : CW) + 2;
    localparam int CNT_W  = $clog2(SQE/2);

    // Registers.
    t_state                 r_state,    n_state;
    logic [SCALE_W-1:0]     r_scale;
    logic signed [CW-1:0]   r_rx,       n_rx;
    logic signed [CW-1:0]   r_ry,       n_ry;
    logic                   r_restart,  n_restart;
    logic signed [CW-1:0]   r_held_x,   n_held_x;
    logic signed [CW-1:0]   r_held_y,   n_held_y;
    logic                   r_primed,   n_primed;
    logic [AX_W-1:0]        r_ax,       n_ax;
    logic [AX_W-1:0]        r_ay,       n_ay;
    logic                   r_negx,     n_negx;
    logic                   r_negy,     n_negy;
    logic [SW-1:0]          r_rem,      n_rem;
    logic [SW-1:0]          r_div,      n_div;
    logic [SQE-1:0]         r_root,     n_root;
    logic [SQE-1:0]         r_bit,      n_bit;
    logic [CNT_W-1:0]       r_cnt,      n_cnt;
    logic [TH_W-1:0]        r_num,      n_num;
    logic [QW-1:0]          r_quo,      n_quo;
    logic [QW-1:0]          r_qx,       n_qx;
    t_action                r_action,   n_action;
    logic                   r_out_valid, n_out_valid;
    logic signed [CW-1:0]   r_out_x,    n_out_x;
    logic signed [CW-1:0]   r_out_y,    n_out_y;
    t_action                r_out_act,  n_out_act;

    // Shared unit connections.
    logic [AX_W-1:0]  w_mul_a;
    logic [TH_W-1:0]  w_mul_b;
    logic [PW-1:0]    w_prod;
    logic [SW-1:0]    w_sub_a;
    logic [SW-1:0]    w_sub_b;
    logic [SW-1:0]    w_diff;
    logic             w_ge;

    // Datapath helpers.
    logic [TH_W-1:0]        w_dead_t;
    logic [TH_W-1:0]        w_snap_t;
    logic signed [DW-1:0]   w_dx;
    logic signed [DW-1:0]   w_dy;
    logic [DW-1:0]          w_adx;
    logic [DW-1:0]          w_ady;
    logic [DW-1:0]          w_m;
    logic [MC_W-1:0]        w_m256;
    logic                   w_far;
    logic [D_W-1:0]         w_d;
    logic [DC_W-1:0]        w_d256;
    logic [DEN_W-1:0]       w_den;
    logic signed [G_W-1:0]  w_step_x;
    logic signed [G_W-1:0]  w_step_y;
    logic signed [CW-1:0]   w_glide_x;
    logic signed [CW-1:0]   w_glide_y;

    dgpf_alu #(
        .A_W (AX_W),
        .B_W (TH_W),
        .S_W (SW)
    ) u_alu (
        .i_mul_a (w_mul_a),
        .i_mul_b (w_mul_b),
        .o_prod  (w_prod),
        .i_sub_a (w_sub_a),
        .i_sub_b (w_sub_b),
        .o_diff  (w_diff),
        .o_ge    (w_ge)
    );

    // Deadband and snap distances in coordinate units times 256.
    assign w_dead_t = TH_W'(r_scale) << (F + 1);
    assign w_snap_t = (TH_W'(r_scale) + (TH_W'(r_scale) << 1)) << (F + 3);

    // Offsets from the held point and their magnitudes.
    assign w_dx  = DW'(r_rx) - DW'(r_held_x);
    assign w_dy  = DW'(r_ry) - DW'(r_held_y);
    assign w_adx = w_dx[DW-1] ? DW'(-w_dx) : DW'(w_dx);
    assign w_ady = w_dy[DW-1] ? DW'(-w_dy) : DW'(w_dy);
    assign w_m   = (w_adx > w_ady) ? w_adx : w_ady;

    // A single axis already at the snap distance settles the word without the root.
    assign w_m256 = MC_W'(w_m) << 8;
    assign w_far  = (w_m256 >= MC_W'(w_snap_t)) && (w_m256 > MC_W'(w_dead_t));

    // Distance after the root, scaled, and the glide divisor.
    assign w_d    = r_root[D_W-1:0];
    assign w_d256 = {w_d, 8'd0};
    assign w_den  = (DEN_W'(w_d) << 10) + (DEN_W'(w_d) << 8);

    // Glide result per axis, truncated toward zero.
    assign w_step_x  = r_negx ? -$signed(G_W'(r_qx))  : $signed(G_W'(r_qx));
    assign w_step_y  = r_negy ? -$signed(G_W'(r_quo)) : $signed(G_W'(r_quo));
    assign w_glide_x = CW'(G_W'(r_held_x) + w_step_x);
    assign w_glide_y = CW'(G_W'(r_held_y) + w_step_y);

    // Sequencer: next state and datapath updates.
    always_comb begin
        n_state     = r_state;
        n_rx        = r_rx;
        n_ry        = r_ry;
        n_restart   = r_restart;
        n_held_x    = r_held_x;
        n_held_y    = r_held_y;
        n_primed    = r_primed;
        n_ax        = r_ax;
        n_ay        = r_ay;
        n_negx      = r_negx;
        n_negy      = r_negy;
        n_rem       = r_rem;
        n_div       = r_div;
        n_root      = r_root;
        n_bit       = r_bit;
        n_cnt       = r_cnt;
        n_num       = r_num;
        n_quo       = r_quo;
        n_qx        = r_qx;
        n_action    = r_action;
        n_out_valid = r_out_valid;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_act   = r_out_act;
        w_mul_a     = r_ax;
        w_mul_b     = r_num;
        w_sub_a     = r_rem;
        w_sub_b     = r_div;

        // The output word leaves when taken.
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_rx      = s_axis_tdata[CW-1:0];
                    n_ry      = s_axis_tdata[2*CW-1:CW];
                    n_restart = s_axis_tuser;
                    n_state   = ST_PREP;
                end
            end
            ST_PREP: begin
                n_ax   = AX_W'(w_adx);
                n_ay   = AX_W'(w_ady);
                n_negx = w_dx[DW-1];
                n_negy = w_dy[DW-1];
                if (r_restart || !r_primed) begin
                    n_action = ACT_FIRST;
                    n_state  = ST_FIN;
                end else if (w_far) begin
                    n_action = ACT_SNAP;
                    n_state  = ST_FIN;
                end else begin
                    n_state  = ST_SQ_X;
                end
            end
            ST_SQ_X: begin
                w_mul_a = r_ax;
                w_mul_b = TH_W'(r_ax);
                n_rem   = SW'(w_prod);
                n_state = ST_SQ_Y;
            end
            ST_SQ_Y: begin
                w_mul_a = r_ay;
                w_mul_b = TH_W'(r_ay);
                n_rem   = r_rem + SW'(w_prod);
                n_root  = '0;
                n_bit   = SQE'(1) << (SQE - 2);
                n_cnt   = CNT_W'(SQE/2 - 1);
                n_state = ST_SQRT;
            end
            ST_SQRT: begin
                // One root bit per cycle.
                w_sub_a = r_rem;
                w_sub_b = SW'(r_root + r_bit);
                if (w_ge) begin
                    n_rem  = w_diff;
                    n_root = (r_root >> 1) + r_bit;
                end else begin
                    n_root = r_root >> 1;
                end
                n_bit = r_bit >> 2;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (w_d256 <= DC_W'(w_dead_t)) begin
                    n_action = ACT_HOLD;
                    n_state  = ST_FIN;
                end else if (w_d256 >= DC_W'(w_snap_t)) begin
                    n_action = ACT_SNAP;
                    n_state  = ST_FIN;
                end else begin
                    n_num    = TH_W'(w_d256 - DC_W'(w_dead_t));
                    n_action = ACT_GLIDE;
                    n_state  = ST_MUL_X;
                end
            end
            ST_MUL_X: begin
                w_mul_a = r_ax;
                w_mul_b = r_num;
                n_rem   = SW'(w_prod);
                n_div   = SW'(w_den) << (QW - 1);
                n_cnt   = CNT_W'(QW - 1);
                n_quo   = '0;
                n_state = ST_DIV_X;
            end
            ST_DIV_X: begin
                // One quotient bit per cycle.
                w_sub_a = r_rem;
                w_sub_b = r_div;
                if (w_ge) begin
                    n_rem = w_diff;
                end
                n_quo = {r_quo[QW-2:0], w_ge};
                n_div = r_div >> 1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_MUL_Y;
                end
            end
            ST_MUL_Y: begin
                n_qx    = r_quo;
                w_mul_a = r_ay;
                w_mul_b = r_num;
                n_rem   = SW'(w_prod);
                n_div   = SW'(w_den) << (QW - 1);
                n_cnt   = CNT_W'(QW - 1);
                n_quo   = '0;
                n_state = ST_DIV_Y;
            end
            ST_DIV_Y: begin
                w_sub_a = r_rem;
                w_sub_b = r_div;
                if (w_ge) begin
                    n_rem = w_diff;
                end
                n_quo = {r_quo[QW-2:0], w_ge};
                n_div = r_div >> 1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                // Commit once the output register is free.
                if (!r_out_valid || m_axis_tready) begin
                    case (r_action)
                        ACT_FIRST, ACT_SNAP: begin
                            n_held_x = r_rx;
                            n_held_y = r_ry;
                        end
                        ACT_GLIDE: begin
                            n_held_x = w_glide_x;
                            n_held_y = w_glide_y;
                        end
                        default: begin
                            n_held_x = r_held_x;
                            n_held_y = r_held_y;
                        end
                    endcase
                    n_primed    = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_x     = n_held_x;
                    n_out_y     = n_held_y;
                    n_out_act   = r_action;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_primed    <= 1'b0;
            r_out_valid <= 1'b0;
            r_held_x    <= '0;
            r_held_y    <= '0;
        end else begin
            r_state     <= n_state;
            r_primed    <= n_primed;
            r_out_valid <= n_out_valid;
            r_held_x    <= n_held_x;
            r_held_y    <= n_held_y;
        end
    end

    // Scale register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
        end else if (i_cfg_valid) begin
            r_scale <= i_cfg_data;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_rx      <= n_rx;
        r_ry      <= n_ry;
        r_restart <= n_restart;
        r_ax      <= n_ax;
        r_ay      <= n_ay;
        r_negx    <= n_negx;
        r_negy    <= n_negy;
        r_rem     <= n_rem;
        r_div     <= n_div;
        r_root    <= n_root;
        r_bit     <= n_bit;
        r_cnt     <= n_cnt;
        r_num     <= n_num;
        r_quo     <= n_quo;
        r_qx      <= n_qx;
        r_action  <= n_action;
        r_out_x   <= n_out_x;
        r_out_y   <= n_out_y;
        r_out_act <= n_out_act;
    end

    // Ports.
    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TD_W'({r_out_y, r_out_x});
    assign m_axis_tuser  = r_out_act;

endmodule

FILE: rtl/dgpf_alu.sv
`timescale 1ns / 1ps

// Shared arithmetic unit: one multiplier and one compare-subtract.
module dgpf_alu #(
    parameter int A_W = 13,
    parameter int B_W = 21,
    parameter int S_W = 34
) (
    input  logic [A_W-1:0]     i_mul_a,
    input  logic [B_W-1:0]     i_mul_b,
    output logic [A_W+B_W-1:0] o_prod,
    input  logic [S_W-1:0]     i_sub_a,
    input  logic [S_W-1:0]     i_sub_b,
    output logic [S_W-1:0]     o_diff,
    output logic               o_ge
);

    logic [S_W:0] w_sub;

    // Unsigned product of the two operands.
    assign o_prod = (A_W+B_W)'(i_mul_a) * (A_W+B_W)'(i_mul_b);

    // Subtract with borrow; no borrow means a is at least b.
    assign w_sub  = {1'b0, i_sub_a} - {1'b0, i_sub_b};
    assign o_diff = w_sub[S_W-1:0];
    assign o_ge   = ~w_sub[S_W];

endmodule
